// ----- rtl/tree_distance_lca_engine_assert.svh -----
// ------------------------------------------------------------------------------------------
// Assertion macros for the tree distance engine
// Short wrappers around concurrent assertions, clocked on clk, disabled while arst_n is low.
// ------------------------------------------------------------------------------------------
`ifndef TREE_DISTANCE_LCA_ENGINE_ASSERT_SVH
`define TREE_DISTANCE_LCA_ENGINE_ASSERT_SVH

// same-cycle implication
`define TDLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdle assertion failed");

// next-cycle implication
`define TDLE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdle assertion failed");

`endif

// ----- rtl/tdle_pkg.sv -----
// ------------------------------------------------------------------------------------------
// tdle_pkg
// Sizes, micro-ops, jump conditions and the control program of the tree distance engine.
// ------------------------------------------------------------------------------------------
package tdle_pkg;

	// tree size
	localparam int MAX_NODES    = 1024;
	localparam int LIFT_LEVELS  = 10;
	localparam int NODE_W       = $clog2(MAX_NODES);
	localparam int NODE_FIELD_W = 10;
	localparam int COST_W       = 16;
	localparam int DEPTH_W      = 11;
	localparam int DIST_W       = 27;
	localparam int LVL_W        = $clog2(LIFT_LEVELS + 1);
	localparam int ANC_DEPTH    = MAX_NODES * LIFT_LEVELS;
	localparam int ANC_AW       = $clog2(ANC_DEPTH);

	// stream widths, whole bytes
	localparam int IN_TDATA_W  = ((2 * NODE_FIELD_W + COST_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((NODE_FIELD_W + DIST_W + 7) / 8) * 8;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

	// micro-ops
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_RD_AB,
		OP_ADD_HEAD,
		OP_FILL_RD,
		OP_FILL_WR,
		OP_Q_ORDER,
		OP_LIFT_RD,
		OP_LIFT_STEP,
		OP_CLIMB_INIT,
		OP_CLIMB_RD,
		OP_CLIMB_STEP,
		OP_ROOT_RD,
		OP_ROOT_SET,
		OP_DIST_RD,
		OP_EMIT
	} uop_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_ACCEPT,
		C_QUERY,
		C_A_ZERO,
		C_LVL_END,
		C_DIFF_ZERO,
		C_UV_EQ,
		C_LVL_NONZERO,
		C_OUT_FREE
	} cond_t;

	// status seen by the sequencer
	typedef struct packed {
		logic no_accept;
		logic query;
		logic a_zero;
		logic lvl_end;
		logic diff_zero;
		logic uv_eq;
		logic lvl_nonzero;
		logic out_free;
	} cond_flags_t;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// program step labels
	localparam step_t S_IDLE       = step_t'(0);
	localparam step_t S_RD_AB      = step_t'(1);
	localparam step_t S_ADD_CHK    = step_t'(2);
	localparam step_t S_ADD_HEAD   = step_t'(3);
	localparam step_t S_FILL_RD    = step_t'(4);
	localparam step_t S_FILL_WR    = step_t'(5);
	localparam step_t S_Q_ORDER    = step_t'(6);
	localparam step_t S_LIFT_RD    = step_t'(7);
	localparam step_t S_LIFT_STEP  = step_t'(8);
	localparam step_t S_CLIMB_INIT = step_t'(9);
	localparam step_t S_CLIMB_RD   = step_t'(10);
	localparam step_t S_CLIMB_STEP = step_t'(11);
	localparam step_t S_ROOT_RD    = step_t'(12);
	localparam step_t S_ROOT_SET   = step_t'(13);
	localparam step_t S_DIST_RD    = step_t'(14);
	localparam step_t S_EMIT       = step_t'(15);
	localparam step_t S_EMIT_WAIT  = step_t'(16);

	// control store: op, jump condition, jump target (else fall through)
	function automatic ucode_t ucode_at(input step_t s);
		ucode_t w;
		unique case (s)
			S_IDLE:       w = '{OP_ACCEPT,     C_NO_ACCEPT,   S_IDLE};
			S_RD_AB:      w = '{OP_RD_AB,      C_QUERY,       S_Q_ORDER};
			S_ADD_CHK:    w = '{OP_NOP,        C_A_ZERO,      S_IDLE};
			S_ADD_HEAD:   w = '{OP_ADD_HEAD,   C_NEXT,        S_IDLE};
			S_FILL_RD:    w = '{OP_FILL_RD,    C_LVL_END,     S_IDLE};
			S_FILL_WR:    w = '{OP_FILL_WR,    C_ALWAYS,      S_FILL_RD};
			S_Q_ORDER:    w = '{OP_Q_ORDER,    C_NEXT,        S_IDLE};
			S_LIFT_RD:    w = '{OP_LIFT_RD,    C_DIFF_ZERO,   S_CLIMB_INIT};
			S_LIFT_STEP:  w = '{OP_LIFT_STEP,  C_ALWAYS,      S_LIFT_RD};
			S_CLIMB_INIT: w = '{OP_CLIMB_INIT, C_UV_EQ,       S_DIST_RD};
			S_CLIMB_RD:   w = '{OP_CLIMB_RD,   C_NEXT,        S_IDLE};
			S_CLIMB_STEP: w = '{OP_CLIMB_STEP, C_LVL_NONZERO, S_CLIMB_RD};
			S_ROOT_RD:    w = '{OP_ROOT_RD,    C_NEXT,        S_IDLE};
			S_ROOT_SET:   w = '{OP_ROOT_SET,   C_NEXT,        S_IDLE};
			S_DIST_RD:    w = '{OP_DIST_RD,    C_NEXT,        S_IDLE};
			S_EMIT:       w = '{OP_EMIT,       C_OUT_FREE,    S_IDLE};
			S_EMIT_WAIT:  w = '{OP_NOP,        C_ALWAYS,      S_EMIT};
			default:      w = '{OP_NOP,        C_ALWAYS,      S_IDLE};
		endcase
		return w;
	endfunction

	// flat address of one ancestor entry: node * LIFT_LEVELS + level
	function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] n,
			input logic [LVL_W-1:0] l);
		return ANC_AW'(ANC_AW'(n) * ANC_AW'(LIFT_LEVELS) + ANC_AW'(l));
	endfunction

endpackage

// ----- rtl/tdle_seq.sv -----
// ------------------------------------------------------------------------------------------
// tdle_seq
// Step counter and control store; picks the next step from the jump condition.
// ------------------------------------------------------------------------------------------
module tdle_seq
	import tdle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cond_flags_t flags,
	output uop_t        op
);

	step_t  step_q;
	ucode_t word;
	logic   take;

	assign word = ucode_at(step_q);
	assign op   = word.op;

	// jump condition
	always_comb begin
		unique case (word.cond)
			C_NEXT:        take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_NO_ACCEPT:   take = flags.no_accept;
			C_QUERY:       take = flags.query;
			C_A_ZERO:      take = flags.a_zero;
			C_LVL_END:     take = flags.lvl_end;
			C_DIFF_ZERO:   take = flags.diff_zero;
			C_UV_EQ:       take = flags.uv_eq;
			C_LVL_NONZERO: take = flags.lvl_nonzero;
			C_OUT_FREE:    take = flags.out_free;
			default:       take = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (take) begin
			step_q <= word.target;
		end else begin
			step_q <= step_q + step_t'(1);
		end
	end

endmodule

// ----- rtl/tree_distance_lca_engine.sv -----
// Add item: node reads, then unless node_a is 0 the depth, distance and parent writes and,
//   per level, one ancestor-table read and one write, with registered read data.
// Query item: node reads, depth order, lift read and step per level to a zero gap, then,
//   unless lifting meets, climb read and step per level and root read; distance read; emit.
// One item at a time; a finished result waits in the output register while the next runs.
// Reset clears the sequencer and output valid only; node 0 always reads as zero.
// ------------------------------------------------------------------------------------------
// tree_distance_lca_engine
// Weighted tree kept in depth, root distance and ancestor tables; answers LCA and distance.
// ------------------------------------------------------------------------------------------
module tree_distance_lca_engine
	import tdle_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // node_a, node_b, edge_cost, zero pad
	input  logic [0:0]             s_axis_tuser,   // kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // common_ancestor, path_distance, zero pad
);

`include "tree_distance_lca_engine_assert.svh"

	uop_t        op;
	cond_flags_t flags;

	// item registers
	logic                   kind_q;
	logic [NODE_W-1:0]      a_q, b_q;
	logic [COST_W-1:0]      cost_q;

	// working registers
	logic [NODE_W-1:0]      u_q, v_q, c_q;
	logic [LVL_W-1:0]       lvl_q;
	logic [LIFT_LEVELS-1:0] diff_q;
	logic [DIST_W:0]        sum_q;

	// tables
	logic [DEPTH_W-1:0] depth_mem [MAX_NODES];
	logic [DIST_W-1:0]  dist_mem  [MAX_NODES];
	logic [NODE_W-1:0]  anc_mem   [ANC_DEPTH];

	// registered read data and node-0 marks
	logic [DEPTH_W-1:0] depth_x_q, depth_y_q;
	logic [DIST_W-1:0]  dist_x_q, dist_y_q;
	logic [NODE_W-1:0]  anc_x_q, anc_y_q;
	logic               nd_x_zero_q, nd_y_zero_q, an_x_zero_q, an_y_zero_q;
	logic [DEPTH_W-1:0] depth_x, depth_y;
	logic [DIST_W-1:0]  dist_x, dist_y;
	logic [NODE_W-1:0]  anc_x, anc_y;

	logic               nd_re, nd_we, anx_re, any_re, anc_we;
	logic [NODE_W-1:0]  nd_x_node, anx_node;
	logic [LVL_W-1:0]   anx_lvl;
	logic [ANC_AW-1:0]  anc_wr_addr;
	logic [NODE_W-1:0]  anc_wr_data;

	logic [DEPTH_W-1:0] new_depth;
	logic [DIST_W:0]    cost_sum;
	logic [DIST_W-1:0]  new_dist;
	logic [DEPTH_W-1:0] depth_delta;
	logic [DIST_W:0]    twice_c;
	logic [DIST_W:0]    pd_raw;
	logic [DIST_W-1:0]  pd;

	logic               in_acc, out_busy, out_load;
	logic               m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	tdle_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	// handshakes
	assign s_axis_tready = (op == OP_ACCEPT);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_busy      = m_valid_q && !m_axis_tready;
	assign out_load      = (op == OP_EMIT) && !out_busy;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// status for the sequencer
	assign flags.no_accept   = !s_axis_tvalid;
	assign flags.query       = kind_q;
	assign flags.a_zero      = (a_q == '0);
	assign flags.lvl_end     = (lvl_q == LVL_W'(LIFT_LEVELS));
	assign flags.diff_zero   = (diff_q == '0);
	assign flags.uv_eq       = (u_q == v_q);
	assign flags.lvl_nonzero = (lvl_q != '0);
	assign flags.out_free    = !out_busy;

	// table port controls
	assign nd_re     = (op == OP_RD_AB) || (op == OP_DIST_RD);
	assign nd_we     = (op == OP_ADD_HEAD);
	assign nd_x_node = (op == OP_DIST_RD) ? c_q : a_q;
	assign anx_re    = (op == OP_FILL_RD) || (op == OP_CLIMB_RD) || (op == OP_ROOT_RD)
		|| ((op == OP_LIFT_RD) && (diff_q != '0));
	assign any_re    = (op == OP_CLIMB_RD);
	assign anc_we    = (op == OP_ADD_HEAD) || (op == OP_FILL_WR);

	// ancestor read port X address
	always_comb begin
		unique case (op)
			OP_FILL_RD: begin
				anx_node = v_q;
				anx_lvl  = lvl_q - LVL_W'(1);
			end
			OP_LIFT_RD: begin
				anx_node = v_q;
				anx_lvl  = lvl_q;
			end
			OP_CLIMB_RD: begin
				anx_node = u_q;
				anx_lvl  = lvl_q;
			end
			default: begin
				anx_node = u_q;
				anx_lvl  = '0;
			end
		endcase
	end

	// ancestor write: parent at level 0, lifted entry at later levels
	assign anc_wr_addr = (op == OP_ADD_HEAD) ? anc_addr(a_q, '0) : anc_addr(a_q, lvl_q);
	assign anc_wr_data = (op == OP_ADD_HEAD) ? b_q : anc_x;

	// node 0 reads as all zero
	assign depth_x = nd_x_zero_q ? '0 : depth_x_q;
	assign depth_y = nd_y_zero_q ? '0 : depth_y_q;
	assign dist_x  = nd_x_zero_q ? '0 : dist_x_q;
	assign dist_y  = nd_y_zero_q ? '0 : dist_y_q;
	assign anc_x   = an_x_zero_q ? '0 : anc_x_q;
	assign anc_y   = an_y_zero_q ? '0 : anc_y_q;

	// depth and root distance of a new node, both saturating
	assign new_depth = (depth_y == DEPTH_MAX) ? DEPTH_MAX : depth_y + DEPTH_W'(1);
	assign cost_sum  = {1'b0, dist_y} + (DIST_W + 1)'(cost_q);
	always_comb begin
		if (b_q == '0) begin
			new_dist = '0;
		end else if (cost_sum[DIST_W]) begin
			new_dist = DIST_MAX;
		end else begin
			new_dist = cost_sum[DIST_W-1:0];
		end
	end

	// depth gap, deeper minus shallower
	assign depth_delta = (depth_y < depth_x) ? depth_x - depth_y : depth_y - depth_x;

	// path distance: sum - 2 * dist(lca), floored at zero, saturating
	assign twice_c = {dist_x, 1'b0};
	assign pd_raw  = (sum_q >= twice_c) ? sum_q - twice_c : '0;
	assign pd      = pd_raw[DIST_W] ? DIST_MAX : pd_raw[DIST_W-1:0];

	// depth and distance tables
	always_ff @(posedge clk) begin
		if (nd_we) begin
			depth_mem[a_q] <= new_depth;
			dist_mem[a_q]  <= new_dist;
		end
		if (nd_re) begin
			depth_x_q   <= depth_mem[nd_x_node];
			dist_x_q    <= dist_mem[nd_x_node];
			depth_y_q   <= depth_mem[b_q];
			dist_y_q    <= dist_mem[b_q];
			nd_x_zero_q <= (nd_x_node == '0);
			nd_y_zero_q <= (b_q == '0);
		end
	end

	// ancestor table
	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[anc_wr_addr] <= anc_wr_data;
		end
		if (anx_re) begin
			anc_x_q     <= anc_mem[anc_addr(anx_node, anx_lvl)];
			an_x_zero_q <= (anx_node == '0);
		end
		if (any_re) begin
			anc_y_q     <= anc_mem[anc_addr(v_q, lvl_q)];
			an_y_zero_q <= (v_q == '0);
		end
	end

	// datapath registers driven by the micro-op
	always_ff @(posedge clk) begin
		unique case (op)
			OP_ACCEPT: begin
				if (s_axis_tvalid) begin
					kind_q <= s_axis_tuser[0];
					a_q    <= s_axis_tdata[NODE_W-1:0];
					b_q    <= s_axis_tdata[NODE_FIELD_W +: NODE_W];
					cost_q <= s_axis_tdata[2*NODE_FIELD_W +: COST_W];
				end
			end
			OP_ADD_HEAD: begin
				v_q   <= b_q;
				lvl_q <= LVL_W'(1);
			end
			OP_FILL_WR: begin
				v_q   <= anc_x;
				lvl_q <= lvl_q + LVL_W'(1);
			end
			OP_Q_ORDER: begin
				sum_q  <= {1'b0, dist_x} + {1'b0, dist_y};
				diff_q <= LIFT_LEVELS'(depth_delta);
				lvl_q  <= '0;
				if (depth_y < depth_x) begin
					u_q <= b_q;
					v_q <= a_q;
				end else begin
					u_q <= a_q;
					v_q <= b_q;
				end
			end
			OP_LIFT_STEP: begin
				if (diff_q[0]) begin
					v_q <= anc_x;
				end
				diff_q <= diff_q >> 1;
				lvl_q  <= lvl_q + LVL_W'(1);
			end
			OP_CLIMB_INIT: begin
				lvl_q <= LVL_W'(LIFT_LEVELS - 1);
				c_q   <= u_q;
			end
			OP_CLIMB_STEP: begin
				if (anc_x != anc_y) begin
					u_q <= anc_x;
					v_q <= anc_y;
				end
				lvl_q <= lvl_q - LVL_W'(1);
			end
			OP_ROOT_SET: begin
				c_q <= anc_x;
			end
			OP_EMIT: begin
				if (!out_busy) begin
					m_data_q <= OUT_TDATA_W'({pd, NODE_FIELD_W'(c_q)});
				end
			end
			default: begin
			end
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// every accepted item starts with the table reads of both nodes
	`TDLE_ASSERT_NXT(a_dispatch, in_acc, op == OP_RD_AB)
	// ancestor rows are written only for a real node; fill levels stay inside the row
	`TDLE_ASSERT_IMP(a_fill_row, anc_we, (a_q != '0) && (nd_we || (lvl_q < LVL_W'(LIFT_LEVELS))))
	// lifting never runs past the top level
	`TDLE_ASSERT_IMP(a_lift_lvl, op == OP_LIFT_STEP, lvl_q < LVL_W'(LIFT_LEVELS))

endmodule
